@@ design/rgb_led_effect_controller_defines.svh @@
// Assertion helpers for the one file that carries checks.
// Every check is clocked on i_clk and switched off while i_rst_n is low.
`ifndef RGB_LED_EFFECT_CONTROLLER_DEFINES_SVH
`define RGB_LED_EFFECT_CONTROLLER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RLEC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RLEC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/rlec_pkg.sv @@
package rlec_pkg;

    localparam int MODE_W   = 4;
    localparam int LEVEL_W  = 12;
    localparam int TIMER_W  = 16;
    localparam int DUTY_W   = 8;
    localparam int LMODE_W  = 7;
    localparam int NUM_CH   = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 12;
    localparam int NUM_COLOURS = 7;

    // Effect constants.
    localparam logic [DUTY_W-1:0]  FADE_PEAK   = 8'd101;
    localparam int                 CYCLE_SLOT  = 200;
    localparam logic [TIMER_W-1:0] BLINK_ON    = 16'd100;
    localparam logic [TIMER_W-1:0] BLINK_TOTAL = 16'd150;

    // User modes.
    localparam logic [MODE_W-1:0] MODE_OFF       = 4'd0;
    localparam logic [MODE_W-1:0] MODE_CYCLE     = 4'd1;
    localparam logic [MODE_W-1:0] MODE_FADE      = 4'd2;
    localparam logic [MODE_W-1:0] MODE_BLINK_LO  = 4'd3;
    localparam logic [MODE_W-1:0] MODE_BLINK_HI  = 4'd9;
    // Stored in place of a mode when no effect has started yet.
    localparam logic [LMODE_W-1:0] MODE_NONE     = 7'd99;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_INTV  = 2'd3;

    // LED bits: bit 0 red, bit 1 green, bit 2 blue.
    localparam logic [NUM_CH-1:0] LED_R = 3'b001;
    localparam logic [NUM_CH-1:0] LED_G = 3'b010;
    localparam logic [NUM_CH-1:0] LED_B = 3'b100;

    localparam logic [NUM_CH-1:0] COLOURS [NUM_COLOURS] = '{
        LED_R, LED_G, LED_B, LED_R | LED_G | LED_B,
        LED_R | LED_G, LED_G | LED_B, LED_R | LED_B
    };

    typedef enum logic [1:0] {
        CS_USER     = 2'd0,
        CS_FULL     = 2'd1,
        CS_CHARGING = 2'd2,
        CS_NONE     = 2'd3
    } t_charge_state;

    typedef enum logic [2:0] {
        FP_RED       = 3'd0,
        FP_GREEN     = 3'd1,
        FP_BLUE      = 3'd2,
        FP_RED_AGAIN = 3'd3,
        FP_CYAN      = 3'd4
    } t_fade_phase;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [LEVEL_W-1:0] charge_level;
        logic               pwm_advance;
        logic               effect_advance;
    } t_tick;

    typedef struct packed {
        logic [LEVEL_W-1:0] idle_limit;
        logic [LEVEL_W-1:0] full_limit;
        logic [DUTY_W-1:0]  pwm_period;
        logic [DUTY_W-1:0]  fade_interval;
    } t_cfg;

    // Returns {slot found, colour}; the timer is past the last slot when no slot is found.
    function automatic logic [NUM_CH:0] cycle_lookup(input logic [TIMER_W-1:0] t);
        logic [NUM_CH:0] res;
        int k;
        res = '0;
        for (k = NUM_COLOURS - 1; k >= 0; k--) begin
            if ({1'b0, t} < (TIMER_W + 1)'((k + 1) * CYCLE_SLOT)) begin
                res = {1'b1, COLOURS[k]};
            end
        end
        return res;
    endfunction

    function automatic logic [DUTY_W-1:0] sat_inc(input logic [DUTY_W-1:0] d);
        return (d == {DUTY_W{1'b1}}) ? d : d + 8'd1;
    endfunction

    function automatic logic [DUTY_W-1:0] sat_dec(input logic [DUTY_W-1:0] d);
        return (d == '0) ? d : d - 8'd1;
    endfunction

endpackage

@@ design/rlec_if.sv @@
interface rlec_tick_if import rlec_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  mode;
    logic [LEVEL_W-1:0] charge_level;
    logic               pwm_advance;
    logic               effect_advance;

    modport source (output valid, mode, charge_level, pwm_advance, effect_advance,
                    input ready);
    modport sink (input valid, mode, charge_level, pwm_advance, effect_advance,
                  output ready);
endinterface

interface rlec_led_if;
    logic valid;
    logic ready;
    logic red_on;
    logic green_on;
    logic blue_on;

    modport source (output valid, red_on, green_on, blue_on, input ready);
    modport sink (input valid, red_on, green_on, blue_on, output ready);
endinterface

interface rlec_cfg_if import rlec_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ design/rlec_cfg_regs.sv @@
module rlec_cfg_regs import rlec_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rlec_cfg_if.sink   i_cfg,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.idle_limit    <= 12'd2;
            r_cfg.full_limit    <= 12'd10;
            r_cfg.pwm_period    <= 8'd100;
            r_cfg.fade_interval <= 8'd10;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_IDLE_LIMIT: r_cfg.idle_limit    <= i_cfg.data;
                REG_FULL_LIMIT: r_cfg.full_limit    <= i_cfg.data;
                REG_PWM_PERIOD: r_cfg.pwm_period    <= i_cfg.data[DUTY_W-1:0];
                REG_FADE_INTV:  r_cfg.fade_interval <= i_cfg.data[DUTY_W-1:0];
                default:        r_cfg               <= r_cfg;
            endcase
        end
    end

endmodule

@@ design/rlec_effect_core.sv @@
module rlec_effect_core import rlec_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  t_tick             i_tick,
    input  t_cfg              i_cfg,
    output logic [NUM_CH-1:0] o_leds
);

    logic [TIMER_W-1:0] r_timer,   n_timer;
    logic [DUTY_W-1:0]  r_cnt  [NUM_CH];
    logic [DUTY_W-1:0]  n_cnt  [NUM_CH];
    logic [DUTY_W-1:0]  r_duty [NUM_CH];
    logic [DUTY_W-1:0]  n_duty [NUM_CH];
    t_fade_phase        r_phase,   n_phase;
    logic [LMODE_W-1:0] r_last_mode, n_last_mode;
    t_charge_state      r_last_cs, n_last_cs;
    logic [NUM_CH-1:0]  r_led,     n_led;

    t_charge_state      cs;
    logic [LMODE_W-1:0] mode_ext;
    logic [NUM_CH:0]    slot;
    logic [NUM_CH-1:0]  rise;
    logic [NUM_CH-1:0]  above;
    t_fade_phase        phase_after;

    assign o_leds   = r_led;
    assign mode_ext = {{(LMODE_W - MODE_W){1'b0}}, i_tick.mode};

    always_comb begin
        n_timer     = r_timer + {{(TIMER_W - 1){1'b0}}, i_tick.effect_advance};
        n_phase     = r_phase;
        n_last_mode = r_last_mode;
        n_last_cs   = r_last_cs;
        n_led       = r_led;
        rise        = '0;
        above       = '0;
        phase_after = FP_RED;
        slot        = '0;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            n_cnt[ch]  = r_cnt[ch] + {{(DUTY_W - 1){1'b0}}, i_tick.pwm_advance};
            n_duty[ch] = r_duty[ch];
        end

        if (i_tick.charge_level < i_cfg.idle_limit) begin
            cs = CS_USER;
        end else if (i_tick.charge_level < i_cfg.full_limit) begin
            cs = CS_FULL;
        end else begin
            cs = CS_CHARGING;
        end

        // A change of charge state forces the next effect to restart.
        if (cs != n_last_cs) begin
            n_last_cs   = cs;
            n_last_mode = MODE_NONE;
        end

        if (cs == CS_FULL) begin
            n_led = '0;
        end else if (cs == CS_CHARGING || i_tick.mode == MODE_CYCLE) begin
            if (n_last_mode != mode_ext) begin
                n_last_mode = mode_ext;
                n_led       = '0;
                n_timer     = '0;
            end
            slot = cycle_lookup(n_timer);
            if (slot[NUM_CH]) begin
                n_led = slot[NUM_CH-1:0];
            end else begin
                n_timer = '0;
            end
        end else if (i_tick.mode == MODE_OFF) begin
            n_led = '0;
        end else if (i_tick.mode == MODE_FADE) begin
            if (n_last_mode != mode_ext) begin
                n_last_mode = mode_ext;
                n_led       = '0;
                n_timer     = '0;
                n_phase     = FP_RED;
                for (int ch = 0; ch < NUM_CH; ch++) begin
                    n_cnt[ch]  = '0;
                    n_duty[ch] = '0;
                end
            end
            if (n_timer > {{(TIMER_W - DUTY_W){1'b0}}, i_cfg.fade_interval}) begin
                n_timer = '0;
                unique case (n_phase)
                    FP_RED: begin
                        rise        = LED_R;
                        phase_after = FP_GREEN;
                    end
                    FP_GREEN: begin
                        rise        = LED_G;
                        phase_after = FP_BLUE;
                    end
                    FP_BLUE: begin
                        rise        = LED_B;
                        phase_after = FP_RED_AGAIN;
                    end
                    FP_RED_AGAIN: begin
                        rise        = LED_R;
                        phase_after = FP_CYAN;
                    end
                    FP_CYAN: begin
                        rise        = LED_G | LED_B;
                        phase_after = FP_RED;
                    end
                    default: begin
                        rise        = '0;
                        phase_after = FP_RED;
                    end
                endcase
                if (rise == '0) begin
                    n_phase = FP_RED;
                end else begin
                    for (int ch = 0; ch < NUM_CH; ch++) begin
                        n_duty[ch] = rise[ch] ? sat_inc(n_duty[ch]) : sat_dec(n_duty[ch]);
                        above[ch]  = n_duty[ch] > FADE_PEAK;
                    end
                    // The phase ends once every ramping channel is past the peak.
                    if (&(~rise | above)) begin
                        n_phase = phase_after;
                    end
                end
            end
            for (int ch = 0; ch < NUM_CH; ch++) begin
                if (n_cnt[ch] < n_duty[ch]) begin
                    n_led[ch] = 1'b1;
                end else if (n_cnt[ch] < i_cfg.pwm_period) begin
                    n_led[ch] = 1'b0;
                end else begin
                    n_cnt[ch] = '0;
                end
            end
        end else if (i_tick.mode <= MODE_BLINK_HI) begin
            if (n_last_mode != mode_ext) begin
                n_last_mode = mode_ext;
                n_timer     = '0;
            end
            if (n_timer < BLINK_ON) begin
                n_led = COLOURS[3'(i_tick.mode - MODE_BLINK_LO)];
            end else if (n_timer < BLINK_TOTAL) begin
                n_led = '0;
            end else begin
                n_timer = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer     <= '0;
            r_phase     <= FP_RED;
            r_last_mode <= MODE_NONE;
            r_last_cs   <= CS_NONE;
            r_led       <= '0;
            for (int ch = 0; ch < NUM_CH; ch++) begin
                r_cnt[ch]  <= '0;
                r_duty[ch] <= '0;
            end
        end else if (i_fire) begin
            r_timer     <= n_timer;
            r_phase     <= n_phase;
            r_last_mode <= n_last_mode;
            r_last_cs   <= n_last_cs;
            r_led       <= n_led;
            for (int ch = 0; ch < NUM_CH; ch++) begin
                r_cnt[ch]  <= n_cnt[ch];
                r_duty[ch] <= n_duty[ch];
            end
        end
    end

endmodule

@@ design/rgb_led_effect_controller.sv @@
// Channel   Direction  Beat contents
// i_tick    in         mode, charge_level, pwm_advance, effect_advance
// o_led     out        red_on, green_on, blue_on
// i_cfg     in         index, data (always ready)
//
// Every input beat produces exactly one output beat, through the input register
// and then the result register. A beat is registered, then evaluated and its
// effect state updated; one beat per clock is sustained while o_led is drained.
// When o_led stalls, the result register and the input register each hold one
// beat before i_tick.ready drops.
// Synchronous active-low reset clears all effect state and loads register defaults.
`include "rgb_led_effect_controller_defines.svh"

module rgb_led_effect_controller import rlec_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rlec_tick_if.sink  i_tick,
    rlec_led_if.source o_led,
    rlec_cfg_if.sink   i_cfg
);

    t_cfg              cfg;
    t_tick             r_in;
    logic              r_in_valid;
    logic              r_out_valid;
    logic              out_free;
    logic              fire;
    logic              in_accept;
    logic [NUM_CH-1:0] leds;

    assign out_free     = !r_out_valid || o_led.ready;
    assign fire         = r_in_valid && out_free;
    assign i_tick.ready = !r_in_valid || out_free;
    assign in_accept    = i_tick.valid && i_tick.ready;

    assign o_led.valid    = r_out_valid;
    assign o_led.red_on   = leds[0];
    assign o_led.green_on = leds[1];
    assign o_led.blue_on  = leds[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (o_led.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in.mode           <= i_tick.mode;
            r_in.charge_level   <= i_tick.charge_level;
            r_in.pwm_advance    <= i_tick.pwm_advance;
            r_in.effect_advance <= i_tick.effect_advance;
        end
    end

    rlec_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // The core's LED register doubles as the result payload: it only changes on fire.
    rlec_effect_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_tick  (r_in),
        .i_cfg   (cfg),
        .o_leds  (leds)
    );

    `RLEC_ASSERT_NXT(a_fire_gives_beat, fire, o_led.valid, "evaluated beat not presented")
    `RLEC_ASSERT_IMP(a_ready_low_only_full, !i_tick.ready,
        r_in_valid && r_out_valid && !o_led.ready, "input stalled with room free")
    `RLEC_ASSERT_NXT(a_mode_off_dark,
        fire && r_in.mode == MODE_OFF && r_in.charge_level < cfg.idle_limit,
        !o_led.red_on && !o_led.green_on && !o_led.blue_on, "mode off lit an LED")
    `RLEC_ASSERT_NXT(a_full_dark,
        fire && r_in.charge_level >= cfg.idle_limit && r_in.charge_level < cfg.full_limit,
        !o_led.red_on && !o_led.green_on && !o_led.blue_on, "full state lit an LED")

endmodule
